// File: rtl/c2e_pkg.sv
// ----------------------------------------------------------------------------
// c2e_pkg
// Shared types, constants and the month length table for the calendar to
// epoch seconds block.
// ----------------------------------------------------------------------------
package c2e_pkg;

  localparam int EPOCH_YEAR_DEF = 1970;
  localparam int YEAR_W         = 12;
  localparam int MONTH_W        = 4;
  localparam int DAY_W          = 5;
  localparam int HOUR_W         = 5;
  localparam int MIN_W          = 6;
  localparam int SEC_W          = 6;
  localparam int ACC_W          = 32;
  localparam int IN_DATA_W      = 40;

  localparam logic [YEAR_W-1:0]  YEAR_LAST     = 12'd2105;
  localparam logic [MONTH_W-1:0] MONTH_FIRST   = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST    = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
  localparam logic [16:0]        SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0]        SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]         SECS_PER_MIN  = 6'd60;
  localparam logic [8:0]         DAYS_YEAR     = 9'd365;
  localparam logic [8:0]         DAYS_LEAP     = 9'd366;

  // accumulator unit opcodes
  localparam logic [1:0] OP_NOP = 2'd0;
  localparam logic [1:0] OP_CLR = 2'd1;
  localparam logic [1:0] OP_ADD = 2'd2;
  localparam logic [1:0] OP_MUL = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [ACC_W-1:0] addend;
  } alu_ctrl_t;

  function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/c2e_leap_trk.sv
// ----------------------------------------------------------------------------
// c2e_leap_trk
// Year walker: steps a year register from the epoch and tracks its residues
// mod 100 and mod 400 so the Gregorian leap flag needs no divider.
// ----------------------------------------------------------------------------
module c2e_leap_trk #(
  parameter int EPOCH_YEAR = c2e_pkg::EPOCH_YEAR_DEF
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  output logic [c2e_pkg::YEAR_W-1:0] year,
  output logic                      leap
);

  localparam logic [c2e_pkg::YEAR_W-1:0] Y_INIT    = c2e_pkg::YEAR_W'(EPOCH_YEAR);
  localparam logic [6:0]                 C100_INIT = 7'(EPOCH_YEAR % 100);
  localparam logic [8:0]                 C400_INIT = 9'(EPOCH_YEAR % 400);

  logic [c2e_pkg::YEAR_W-1:0] year_r;
  logic [6:0]                 c100_r;
  logic [8:0]                 c400_r;

  always_ff @(posedge clk) begin
    if (load) begin
      year_r <= Y_INIT;
      c100_r <= C100_INIT;
      c400_r <= C400_INIT;
    end else if (step) begin
      year_r <= year_r + 1'b1;
      c100_r <= (c100_r == 7'd99)  ? 7'd0 : c100_r + 7'd1;
      c400_r <= (c400_r == 9'd399) ? 9'd0 : c400_r + 9'd1;
    end
  end

  assign year = year_r;
  assign leap = ((year_r[1:0] == 2'b00) && (c100_r != 7'd0)) || (c400_r == 9'd0);

endmodule

// File: rtl/c2e_alu.sv
// ----------------------------------------------------------------------------
// c2e_alu
// Shared accumulator: clear, add an operand, scale by the seconds per day, or hold.
// ----------------------------------------------------------------------------
module c2e_alu (
  input  logic                      clk,
  input  c2e_pkg::alu_ctrl_t        ctrl,
  output logic [c2e_pkg::ACC_W-1:0] acc
);

  logic [c2e_pkg::ACC_W-1:0] acc_r;
  logic [c2e_pkg::ACC_W-1:0] acc_nxt;
  logic [c2e_pkg::ACC_W+16:0] prod;

  assign prod = acc_r * c2e_pkg::SECS_PER_DAY;

  always_comb begin
    case (ctrl.op)
      c2e_pkg::OP_CLR: acc_nxt = '0;
      c2e_pkg::OP_ADD: acc_nxt = acc_r + ctrl.addend;
      c2e_pkg::OP_MUL: acc_nxt = prod[c2e_pkg::ACC_W-1:0];
      default:         acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// File: rtl/calendar_to_epoch_seconds_core.sv
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds_core
// Converts an RTC calendar date and time into seconds since the epoch.
//
// Input channel in_*: one word per conversion, accepted on in_tvalid and
// in_tready. in_tready is high only while the sequencer is idle.
// Output channel out_*: one word per input, held in an output register until
// out_tready; the next input may be taken while that word still waits.
// The result is built by the single accumulator doing one add per elapsed
// year and month, then day, the day scaling multiply, hour, minute and second.
// No new word is taken until the last one is loaded into the output register;
// the next word can be taken once out_tvalid rises. A year or month out of
// range skips to the final state and returns 0 with the range error flag.
// If the output register is still full and out_tready stays low, the
// finished word waits in the sequencer's final state and no further input
// is taken.
// Reset (rst_n, synchronous, active low) returns the sequencer to idle and
// empties the output register.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds_core #(
  parameter int EPOCH_YEAR = c2e_pkg::EPOCH_YEAR_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // cal_year[11:0], cal_month[15:12], cal_day[20:16], cal_hour[25:21],
  // cal_minute[31:26], cal_second[37:32], zero pad[39:38]
  input  logic [c2e_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // epoch_seconds[31:0]
  output logic [c2e_pkg::ACC_W-1:0]     out_tdata,
  // range_error[0]
  output logic [0:0]                    out_tuser
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_YEAR  = 4'd1;
  localparam logic [3:0] ST_MONTH = 4'd2;
  localparam logic [3:0] ST_DAY   = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_HOUR  = 4'd5;
  localparam logic [3:0] ST_MIN   = 4'd6;
  localparam logic [3:0] ST_SEC   = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  localparam logic [c2e_pkg::YEAR_W-1:0] EPOCH_Y = c2e_pkg::YEAR_W'(EPOCH_YEAR);

  logic [3:0] state_r, state_nxt;

  logic [c2e_pkg::YEAR_W-1:0]  year_r;
  logic [c2e_pkg::MONTH_W-1:0] month_r;
  logic [c2e_pkg::DAY_W-1:0]   day_r;
  logic [c2e_pkg::HOUR_W-1:0]  hour_r;
  logic [c2e_pkg::MIN_W-1:0]   minute_r;
  logic [c2e_pkg::SEC_W-1:0]   second_r;
  logic                        err_r, err_nxt;
  logic [c2e_pkg::MONTH_W-1:0] m_r, m_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [c2e_pkg::ACC_W-1:0]   out_data_r;
  logic                        out_err_r;
  logic                        out_load;

  logic [c2e_pkg::YEAR_W-1:0]  in_year;
  logic [c2e_pkg::MONTH_W-1:0] in_month;
  logic                        in_bad;
  logic                        in_fire;

  c2e_pkg::alu_ctrl_t          ctrl;
  logic [c2e_pkg::ACC_W-1:0]   acc;
  logic                        yr_load, yr_step;
  logic [c2e_pkg::YEAR_W-1:0]  yr_cur;
  logic                        yr_leap;

  logic [16:0]                 hour_secs;
  logic [11:0]                 min_secs;
  logic [4:0]                  mlen;

  assign in_year  = in_tdata[11:0];
  assign in_month = in_tdata[15:12];
  assign in_bad   = (in_year < EPOCH_Y) || (in_year > c2e_pkg::YEAR_LAST) ||
                    (in_month < c2e_pkg::MONTH_FIRST) || (in_month > c2e_pkg::MONTH_LAST);
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign hour_secs = 17'(hour_r) * 17'(c2e_pkg::SECS_PER_HOUR);
  assign min_secs  = 12'(minute_r) * 12'(c2e_pkg::SECS_PER_MIN);
  assign mlen      = c2e_pkg::month_len(m_r);

  c2e_leap_trk #(
    .EPOCH_YEAR (EPOCH_YEAR)
  ) u_leap (
    .clk  (clk),
    .load (yr_load),
    .step (yr_step),
    .year (yr_cur),
    .leap (yr_leap)
  );

  c2e_alu u_alu (
    .clk  (clk),
    .ctrl (ctrl),
    .acc  (acc)
  );

  always_comb begin
    state_nxt   = state_r;
    err_nxt     = err_r;
    m_nxt       = m_r;
    ctrl.op     = c2e_pkg::OP_NOP;
    ctrl.addend = '0;
    yr_load     = 1'b0;
    yr_step     = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ctrl.op   = c2e_pkg::OP_CLR;
          yr_load   = 1'b1;
          m_nxt     = c2e_pkg::MONTH_FIRST;
          err_nxt   = in_bad;
          state_nxt = in_bad ? ST_FIN : ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (yr_cur < year_r) begin
          ctrl.op     = c2e_pkg::OP_ADD;
          ctrl.addend = c2e_pkg::ACC_W'(yr_leap ? c2e_pkg::DAYS_LEAP : c2e_pkg::DAYS_YEAR);
          yr_step     = 1'b1;
        end else begin
          // walker now sits on the input year: leap flag is for February
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (m_r < month_r) begin
          ctrl.op     = c2e_pkg::OP_ADD;
          ctrl.addend = c2e_pkg::ACC_W'(mlen) +
                        c2e_pkg::ACC_W'((m_r == c2e_pkg::MONTH_FEB) && yr_leap);
          m_nxt       = m_r + 1'b1;
        end else begin
          state_nxt = ST_DAY;
        end
      end
      ST_DAY: begin
        // day zero wraps to all ones, matching the mod 2^32 sum
        ctrl.op     = c2e_pkg::OP_ADD;
        ctrl.addend = c2e_pkg::ACC_W'(day_r) - 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        ctrl.op   = c2e_pkg::OP_MUL;
        state_nxt = ST_HOUR;
      end
      ST_HOUR: begin
        ctrl.op     = c2e_pkg::OP_ADD;
        ctrl.addend = c2e_pkg::ACC_W'(hour_secs);
        state_nxt   = ST_MIN;
      end
      ST_MIN: begin
        ctrl.op     = c2e_pkg::OP_ADD;
        ctrl.addend = c2e_pkg::ACC_W'(min_secs);
        state_nxt   = ST_SEC;
      end
      ST_SEC: begin
        ctrl.op     = c2e_pkg::OP_ADD;
        ctrl.addend = c2e_pkg::ACC_W'(second_r);
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    m_r   <= m_nxt;
    if (in_fire) begin
      year_r   <= in_tdata[11:0];
      month_r  <= in_tdata[15:12];
      day_r    <= in_tdata[20:16];
      hour_r   <= in_tdata[25:21];
      minute_r <= in_tdata[31:26];
      second_r <= in_tdata[37:32];
    end
    if (out_load) begin
      out_data_r <= err_r ? '0 : acc;
      out_err_r  <= err_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_err_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("range error word carries a nonzero timestamp");

  a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_YEAR |-> yr_cur <= year_r)
    else $error("year walker passed the input year");

  a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MONTH |-> m_r <= month_r && m_r >= c2e_pkg::MONTH_FIRST)
    else $error("month counter out of bounds");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("sequencer idle right after accepting a word");
`endif

endmodule
